[hw/rtl/schnorr_proof_verify_defines.svh]
// ----------------------------------------------------------------------------
// schnorr proof verifier assertion macros
// shared concurrent assertion wrappers, clocked on clk_i, reset by rst_ni
// ----------------------------------------------------------------------------
`ifndef SCHNORR_PROOF_VERIFY_DEFINES_SVH
`define SCHNORR_PROOF_VERIFY_DEFINES_SVH

// same-cycle implication
`define SPV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spv assertion failed");

// next-cycle implication
`define SPV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spv assertion failed");

`endif

[hw/rtl/spv_pkg.sv]
// ----------------------------------------------------------------------------
// spv_pkg
// shared types, codes and sha-256 helpers of the schnorr proof verifier
// ----------------------------------------------------------------------------
package spv_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned CfgIdxW = 64;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegModulus   = 64'd0;
  localparam logic [CfgIdxW-1:0] RegGenerator = 64'd1;
  localparam logic [CfgIdxW-1:0] RegPublicKey = 64'd2;

  localparam logic [WordW-1:0] ModulusReset   = 64'd5;
  localparam logic [WordW-1:0] GeneratorReset = 64'd2;
  localparam logic [WordW-1:0] PublicKeyReset = 64'd1;

  // reject reasons
  localparam logic [2:0] ReasonOk       = 3'd0;
  localparam logic [2:0] ReasonARange   = 3'd1;
  localparam logic [2:0] ReasonZRange   = 3'd2;
  localparam logic [2:0] ReasonMismatch = 3'd3;
  localparam logic [2:0] ReasonEquation = 3'd4;

  // reduction targets
  localparam logic [1:0] RedHash = 2'd0;
  localparam logic [1:0] RedGen  = 2'd1;
  localparam logic [1:0] RedKey  = 2'd2;

  // multiply selects
  localparam logic [1:0] MulRb = 2'd0; // r = r * b
  localparam logic [1:0] MulBb = 2'd1; // b = b * b
  localparam logic [1:0] MulAr = 2'd2; // r = A * r

  // power base select
  localparam logic PowGen = 1'b0;
  localparam logic PowKey = 1'b1;

  localparam logic [31:0] ShaInit0 = 32'h6a09e667;
  localparam logic [31:0] ShaInit1 = 32'hbb67ae85;
  localparam logic [31:0] ShaInit2 = 32'h3c6ef372;
  localparam logic [31:0] ShaInit3 = 32'ha54ff53a;
  localparam logic [31:0] ShaInit4 = 32'h510e527f;
  localparam logic [31:0] ShaInit5 = 32'h9b05688c;
  localparam logic [31:0] ShaInit6 = 32'h1f83d9ab;
  localparam logic [31:0] ShaInit7 = 32'h5be0cd19;

  typedef struct packed {
    logic       load;
    logic       sha_start;
    logic       red_start;
    logic [1:0] red_sel;
    logic       mul_start;
    logic [1:0] mul_sel;
    logic       pow_init;
    logic       pow_sel;
    logic       exp_shift;
    logic       save_left;
  } cmd_t;

  typedef struct packed {
    logic a_bad;
    logic z_bad;
    logic sha_done;
    logic red_done;
    logic mul_done;
    logic hash_ok;
    logic exp_lsb;
    logic eq_ok;
  } sts_t;

  function automatic logic [31:0] bswap32(input logic [31:0] v);
    bswap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] sha_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    sha_k = k;
  endfunction

endpackage

[hw/rtl/spv_datapath.sv]
// ----------------------------------------------------------------------------
// spv_datapath
// config registers, sha-256 round engine, serial reducer, shift-add multiplier
// ----------------------------------------------------------------------------
module spv_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [spv_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [spv_pkg::WordW-1:0]         cfg_wdata_i,
  input  logic [spv_pkg::WordW-1:0]         commitment_i,
  input  logic [spv_pkg::WordW-1:0]         challenge_i,
  input  logic [spv_pkg::WordW-1:0]         response_i,
  input  spv_pkg::cmd_t                     cmd_i,
  output spv_pkg::sts_t                     sts_o
);

  localparam int unsigned W = spv_pkg::WordW;

  logic [W-1:0] p_q, g_q, x_q;
  logic [W-1:0] a_q, c_q, z_q;
  logic [W-1:0] pm1;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= spv_pkg::ModulusReset;
      g_q <= spv_pkg::GeneratorReset;
      x_q <= spv_pkg::PublicKeyReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == spv_pkg::RegModulus)   p_q <= cfg_wdata_i;
      if (cfg_index_i == spv_pkg::RegGenerator) g_q <= cfg_wdata_i;
      if (cfg_index_i == spv_pkg::RegPublicKey) x_q <= cfg_wdata_i;
    end
  end

  // proof capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q <= commitment_i;
      c_q <= challenge_i;
      z_q <= response_i;
    end
  end

  assign pm1 = p_q - 64'd1;

  // ---------------- sha-256, one round a cycle ----------------
  logic [31:0] wv_q [8];
  logic [31:0] ws_q [16];
  logic [31:0] wv_n [8];
  logic [31:0] w_new, t1, t2, s0, s1;
  logic [5:0]  sha_cnt_q;
  logic        sha_busy_q, sha_done_q;
  logic [W-1:0] hw_q;

  always_comb begin
    s0 = spv_pkg::rotr(ws_q[1], 7) ^ spv_pkg::rotr(ws_q[1], 18) ^ (ws_q[1] >> 3);
    s1 = spv_pkg::rotr(ws_q[14], 17) ^ spv_pkg::rotr(ws_q[14], 19) ^ (ws_q[14] >> 10);
    w_new = ws_q[0] + s0 + ws_q[9] + s1;
    t1 = wv_q[7] + (spv_pkg::rotr(wv_q[4], 6) ^ spv_pkg::rotr(wv_q[4], 11)
         ^ spv_pkg::rotr(wv_q[4], 25)) + ((wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]))
         + spv_pkg::sha_k(sha_cnt_q) + ws_q[0];
    t2 = (spv_pkg::rotr(wv_q[0], 2) ^ spv_pkg::rotr(wv_q[0], 13)
         ^ spv_pkg::rotr(wv_q[0], 22))
         + ((wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]));
    wv_n[0] = t1 + t2;
    wv_n[1] = wv_q[0];
    wv_n[2] = wv_q[1];
    wv_n[3] = wv_q[2];
    wv_n[4] = wv_q[3] + t1;
    wv_n[5] = wv_q[4];
    wv_n[6] = wv_q[5];
    wv_n[7] = wv_q[6];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sha_busy_q <= 1'b0;
      sha_done_q <= 1'b0;
      sha_cnt_q  <= '0;
    end else begin
      sha_done_q <= sha_busy_q && (sha_cnt_q == 6'd63);
      if (cmd_i.sha_start) begin
        sha_busy_q <= 1'b1;
        sha_cnt_q  <= '0;
      end else if (sha_busy_q) begin
        sha_cnt_q <= sha_cnt_q + 6'd1;
        if (sha_cnt_q == 6'd63) sha_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sha_start) begin
      wv_q[0] <= spv_pkg::ShaInit0; wv_q[1] <= spv_pkg::ShaInit1;
      wv_q[2] <= spv_pkg::ShaInit2; wv_q[3] <= spv_pkg::ShaInit3;
      wv_q[4] <= spv_pkg::ShaInit4; wv_q[5] <= spv_pkg::ShaInit5;
      wv_q[6] <= spv_pkg::ShaInit6; wv_q[7] <= spv_pkg::ShaInit7;
      // message: g, X, A, p as little-endian bytes, then padding
      ws_q[0]  <= spv_pkg::bswap32(g_q[31:0]);
      ws_q[1]  <= spv_pkg::bswap32(g_q[63:32]);
      ws_q[2]  <= spv_pkg::bswap32(x_q[31:0]);
      ws_q[3]  <= spv_pkg::bswap32(x_q[63:32]);
      ws_q[4]  <= spv_pkg::bswap32(a_q[31:0]);
      ws_q[5]  <= spv_pkg::bswap32(a_q[63:32]);
      ws_q[6]  <= spv_pkg::bswap32(p_q[31:0]);
      ws_q[7]  <= spv_pkg::bswap32(p_q[63:32]);
      ws_q[8]  <= 32'h80000000;
      for (int i = 9; i < 15; i++) ws_q[i] <= 32'h0;
      ws_q[15] <= 32'h00000100;
    end else if (sha_busy_q) begin
      for (int i = 0; i < 8; i++) wv_q[i] <= wv_n[i];
      for (int i = 0; i < 15; i++) ws_q[i] <= ws_q[i+1];
      ws_q[15] <= w_new;
      if (sha_cnt_q == 6'd63) begin
        hw_q <= {spv_pkg::bswap32(spv_pkg::ShaInit1 + wv_n[1]),
                 spv_pkg::bswap32(spv_pkg::ShaInit0 + wv_n[0])};
      end
    end
  end

  // ---------------- serial reducer, one dividend bit a cycle ----------------
  logic [W-1:0] rd_opd_q, rd_rem_q, rd_mod_q;
  logic [1:0]   rd_sel_q;
  logic [5:0]   rd_cnt_q;
  logic         rd_busy_q, rd_done_q;
  logic [W:0]   rd_t, rd_s;
  logic [W-1:0] rd_next;
  logic [W-1:0] hres_q, gr_q, xr_q;

  always_comb begin
    rd_t    = {rd_rem_q, rd_opd_q[W-1]};
    rd_s    = rd_t - {1'b0, rd_mod_q};
    rd_next = (rd_t >= {1'b0, rd_mod_q}) ? rd_s[W-1:0] : rd_t[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_busy_q <= 1'b0;
      rd_done_q <= 1'b0;
      rd_cnt_q  <= '0;
    end else begin
      rd_done_q <= rd_busy_q && (rd_cnt_q == 6'd63);
      if (cmd_i.red_start) begin
        rd_busy_q <= 1'b1;
        rd_cnt_q  <= '0;
      end else if (rd_busy_q) begin
        rd_cnt_q <= rd_cnt_q + 6'd1;
        if (rd_cnt_q == 6'd63) rd_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.red_start) begin
      rd_sel_q <= cmd_i.red_sel;
      rd_rem_q <= '0;
      case (cmd_i.red_sel)
        spv_pkg::RedHash: begin rd_opd_q <= hw_q; rd_mod_q <= pm1; end
        spv_pkg::RedGen:  begin rd_opd_q <= g_q;  rd_mod_q <= p_q; end
        default:          begin rd_opd_q <= x_q;  rd_mod_q <= p_q; end
      endcase
    end else if (rd_busy_q) begin
      rd_rem_q <= rd_next;
      rd_opd_q <= {rd_opd_q[W-2:0], 1'b0};
      if (rd_cnt_q == 6'd63) begin
        case (rd_sel_q)
          spv_pkg::RedHash: hres_q <= rd_next;
          spv_pkg::RedGen:  gr_q   <= rd_next;
          default:          xr_q   <= rd_next;
        endcase
      end
    end
  end

  // ---------------- shift-add modular multiplier, msb first ----------------
  logic [W-1:0] mx_q, my_q, acc_q;
  logic [W-1:0] r_q, b_q, e_q, left_q;
  logic [1:0]   mul_sel_q;
  logic [5:0]   mul_cnt_q;
  logic         mul_busy_q, mul_done_q;
  logic [W:0]   dbl, dbl_s, sum, sum_s;
  logic [W-1:0] dbl_r, acc_next;

  always_comb begin
    dbl   = {acc_q, 1'b0};
    dbl_s = dbl - {1'b0, p_q};
    dbl_r = (dbl >= {1'b0, p_q}) ? dbl_s[W-1:0] : dbl[W-1:0];
    sum   = {1'b0, dbl_r} + {1'b0, mx_q};
    sum_s = sum - {1'b0, p_q};
    if (my_q[W-1]) begin
      acc_next = (sum >= {1'b0, p_q}) ? sum_s[W-1:0] : sum[W-1:0];
    end else begin
      acc_next = dbl_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_busy_q <= 1'b0;
      mul_done_q <= 1'b0;
      mul_cnt_q  <= '0;
    end else begin
      mul_done_q <= mul_busy_q && (mul_cnt_q == 6'd63);
      if (cmd_i.mul_start) begin
        mul_busy_q <= 1'b1;
        mul_cnt_q  <= '0;
      end else if (mul_busy_q) begin
        mul_cnt_q <= mul_cnt_q + 6'd1;
        if (mul_cnt_q == 6'd63) mul_busy_q <= 1'b0;
      end
    end
  end

  // multiplier operands and exponent registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      mul_sel_q <= cmd_i.mul_sel;
      acc_q     <= '0;
      mx_q      <= (cmd_i.mul_sel == spv_pkg::MulAr) ? a_q : b_q;
      my_q      <= (cmd_i.mul_sel == spv_pkg::MulBb) ? b_q : r_q;
    end else if (mul_busy_q) begin
      acc_q <= acc_next;
      my_q  <= {my_q[W-2:0], 1'b0};
    end
    if (cmd_i.pow_init) begin
      r_q <= 64'd1;
      b_q <= (cmd_i.pow_sel == spv_pkg::PowKey) ? xr_q : gr_q;
      e_q <= (cmd_i.pow_sel == spv_pkg::PowKey) ? c_q : z_q;
    end else begin
      if (mul_busy_q && (mul_cnt_q == 6'd63)) begin
        if (mul_sel_q == spv_pkg::MulBb) b_q <= acc_next;
        else r_q <= acc_next;
      end
      if (cmd_i.exp_shift) e_q <= {1'b0, e_q[W-1:1]};
    end
    if (cmd_i.save_left) left_q <= r_q;
  end

  // status
  always_comb begin
    sts_o.a_bad    = (a_q == '0) || (a_q >= p_q);
    sts_o.z_bad    = (z_q >= pm1);
    sts_o.sha_done = sha_done_q;
    sts_o.red_done = rd_done_q;
    sts_o.mul_done = mul_done_q;
    sts_o.hash_ok  = (hres_q == c_q);
    sts_o.exp_lsb  = e_q[0];
    sts_o.eq_ok    = (left_q == r_q);
  end

endmodule

[hw/rtl/spv_ctrl.sv]
// ----------------------------------------------------------------------------
// spv_ctrl
// verification sequencer and result register
// ----------------------------------------------------------------------------
module spv_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [2:0]    out_reason_o,
  output spv_pkg::cmd_t cmd_o,
  input  spv_pkg::sts_t sts_i
);

  `include "schnorr_proof_verify_defines.svh"

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SCheck = 4'd1;
  localparam logic [3:0] SSha   = 4'd2;
  localparam logic [3:0] SHred  = 4'd3;
  localparam logic [3:0] SHcmp  = 4'd4;
  localparam logic [3:0] SGred  = 4'd5;
  localparam logic [3:0] SXred  = 4'd6;
  localparam logic [3:0] SPbit  = 4'd7;
  localparam logic [3:0] SPmul  = 4'd8;
  localparam logic [3:0] SPsq   = 4'd9;
  localparam logic [3:0] SFmul  = 4'd10;
  localparam logic [3:0] SFin   = 4'd11;

  logic [3:0] state_q, state_d;
  logic [2:0] reason_q, reason_d;
  logic [5:0] bit_q, bit_d;
  logic       second_q, second_d;
  logic       out_valid_q;
  logic [2:0] out_reason_q;
  logic       out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == SIdle);

  // next state and datapath commands
  always_comb begin
    state_d  = state_q;
    reason_d = reason_q;
    bit_d    = bit_q;
    second_d = second_q;
    cmd_o    = '0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = SCheck;
        end
      end
      SCheck: begin
        if (sts_i.a_bad) begin
          reason_d = spv_pkg::ReasonARange;
          state_d  = SFin;
        end else if (sts_i.z_bad) begin
          reason_d = spv_pkg::ReasonZRange;
          state_d  = SFin;
        end else begin
          cmd_o.sha_start = 1'b1;
          state_d         = SSha;
        end
      end
      SSha: begin
        if (sts_i.sha_done) begin
          cmd_o.red_start = 1'b1;
          cmd_o.red_sel   = spv_pkg::RedHash;
          state_d         = SHred;
        end
      end
      SHred: begin
        if (sts_i.red_done) state_d = SHcmp;
      end
      SHcmp: begin
        if (!sts_i.hash_ok) begin
          reason_d = spv_pkg::ReasonMismatch;
          state_d  = SFin;
        end else begin
          cmd_o.red_start = 1'b1;
          cmd_o.red_sel   = spv_pkg::RedGen;
          state_d         = SGred;
        end
      end
      SGred: begin
        if (sts_i.red_done) begin
          cmd_o.red_start = 1'b1;
          cmd_o.red_sel   = spv_pkg::RedKey;
          state_d         = SXred;
        end
      end
      SXred: begin
        if (sts_i.red_done) begin
          cmd_o.pow_init = 1'b1;
          cmd_o.pow_sel  = spv_pkg::PowGen;
          bit_d          = '0;
          second_d       = 1'b0;
          state_d        = SPbit;
        end
      end
      SPbit: begin
        cmd_o.mul_start = 1'b1;
        if (sts_i.exp_lsb) begin
          cmd_o.mul_sel = spv_pkg::MulRb;
          state_d       = SPmul;
        end else begin
          cmd_o.mul_sel = spv_pkg::MulBb;
          state_d       = SPsq;
        end
      end
      SPmul: begin
        if (sts_i.mul_done) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = spv_pkg::MulBb;
          state_d         = SPsq;
        end
      end
      SPsq: begin
        if (sts_i.mul_done) begin
          if (bit_q != 6'd63) begin
            cmd_o.exp_shift = 1'b1;
            bit_d           = bit_q + 6'd1;
            state_d         = SPbit;
          end else if (!second_q) begin
            cmd_o.save_left = 1'b1;
            cmd_o.pow_init  = 1'b1;
            cmd_o.pow_sel   = spv_pkg::PowKey;
            bit_d           = '0;
            second_d        = 1'b1;
            state_d         = SPbit;
          end else begin
            cmd_o.mul_start = 1'b1;
            cmd_o.mul_sel   = spv_pkg::MulAr;
            state_d         = SFmul;
          end
        end
      end
      SFmul: begin
        if (sts_i.mul_done) begin
          reason_d = sts_i.eq_ok ? spv_pkg::ReasonOk : spv_pkg::ReasonEquation;
          state_d  = SFin;
        end
      end
      SFin: begin
        if (out_free) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      reason_q <= spv_pkg::ReasonOk;
      bit_q    <= '0;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      reason_q <= reason_d;
      bit_q    <= bit_d;
      second_q <= second_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_reason_q <= spv_pkg::ReasonOk;
    end else if ((state_q == SFin) && out_free) begin
      out_valid_q  <= 1'b1;
      out_reason_q <= reason_q;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_reason_o = out_reason_q;

  // a finished item always lands in the result register
  `SPV_ASSERT_NEXT(a_fin_lands, (state_q == SFin) && out_free, (state_q == SIdle) && out_valid_q)
  // a commitment out of range goes straight to the verdict
  `SPV_ASSERT_NEXT(a_range_fast, (state_q == SCheck) && sts_i.a_bad, (state_q == SFin) && (reason_q == spv_pkg::ReasonARange))
  // multiplies are only launched while exponentiating
  `SPV_ASSERT_NEXT(a_mul_state, cmd_o.mul_start, (state_q == SPmul) || (state_q == SPsq) || (state_q == SFmul))

endmodule

[hw/rtl/schnorr_proof_verify.sv]
// ----------------------------------------------------------------------------
// schnorr_proof_verify
// non-interactive schnorr proof verifier over a 64-bit prime group
// ----------------------------------------------------------------------------
// One proof is worked on at a time. A proof rejected on range stops at the
// range check; one rejected on the challenge also runs 64 sha-256 rounds
// and a 64-step bit-serial reduction mod p-1. A full check adds two base
// reductions and two 64-bit exponentiations plus a final multiply, each
// multiply done by the bit-serial shift-add unit: a squaring per exponent
// bit and one more multiply per set bit of z and of c. The shift-add modular
// multiplier dominates a full check. The next proof is taken while a verdict
// still waits in the output register.
module schnorr_proof_verify (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [191:0]  s_axis_tdata,  // commitment, challenge, response
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [7:0]    m_axis_tdata,  // accepted, reject_reason, zero fill
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [63:0]   cfg_index_i,
  input  logic [63:0]   cfg_data_i
);

  spv_pkg::cmd_t cmd;
  spv_pkg::sts_t sts;
  logic [2:0]    reason;

  assign cfg_ready_o = 1'b1;

  spv_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_reason_o (reason),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  spv_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_data_i),
    .commitment_i (s_axis_tdata[63:0]),
    .challenge_i  (s_axis_tdata[127:64]),
    .response_i   (s_axis_tdata[191:128]),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

  // result beat
  assign m_axis_tdata = {4'b0000, reason, (reason == spv_pkg::ReasonOk)};

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// schnorr proof verifier testbench
// drives proofs over the input stream under random stalls and checks every
// verdict against a local model of range checks, sha-256 challenge and powers
// ----------------------------------------------------------------------------
module tb;

  typedef logic [63:0]  word_t;
  typedef logic [127:0] dword_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] reason;
  } verdict_t;

  typedef struct packed {
    word_t a;
    word_t c;
    word_t z;
  } proof_t;

  // directed row kinds
  typedef enum logic [1:0] {RowRaw, RowHonest, RowForged} row_kind_e;

  typedef struct {
    row_kind_e kind;
    word_t     p;
    word_t     g;
    word_t     key;     // public key, or secret for honest and forged rows
    word_t     a;       // commitment, or nonce for honest and forged rows
    word_t     c;
    word_t     z;
    bit        typed;   // expected reason typed in below
    logic [2:0] reason;
  } row_t;

  localparam word_t MaxWord  = 64'hffff_ffff_ffff_ffff;
  localparam word_t BigPrime = 64'hffff_ffff_ffff_ffc5;
  localparam int    RandomItems = 120;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata;   // commitment, challenge, response
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [7:0]   m_axis_tdata;   // accepted, reject_reason, zero fill
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [63:0]  cfg_index_i;
  logic [63:0]  cfg_data_i;

  schnorr_proof_verify DUT (.*);

  // register shadow
  word_t mod_q, gen_q, key_q;

  verdict_t verdict_q[$];
  int       mismatches;
  int       verdicts_seen;
  int       accepted_seen;
  int       proofs_sent;
  bit       hold_rx;

  word_t prime_list[10] = '{64'd3, 64'd5, 64'd7, 64'd11, 64'd13, 64'd65537,
                            64'd1000000007, 64'd4294967291,
                            64'h1fff_ffff_ffff_ffff, BigPrime};

  logic [31:0] round_k[64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  // clock and reset
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [31:0] ror32(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] swap_bytes(logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // sha-256 of g, X, A, p as little-endian bytes; first 8 digest bytes, LE
  function automatic word_t challenge_hash(word_t g, word_t x, word_t a, word_t p);
    logic [31:0] w[64];
    logic [31:0] h[8];
    logic [31:0] s0, s1, t1, t2;
    word_t       msg[4];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    msg = '{g, x, a, p};
    for (int i = 0; i < 4; i++) begin
      w[2*i]   = swap_bytes(msg[i][31:0]);
      w[2*i+1] = swap_bytes(msg[i][63:32]);
    end
    for (int i = 8; i < 16; i++) w[i] = '0;
    w[8]  = 32'h8000_0000;
    w[15] = 32'h0000_0100;
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 64; i++) begin
      t1 = h[7] + (ror32(h[4], 6) ^ ror32(h[4], 11) ^ ror32(h[4], 25)) +
           ((h[4] & h[5]) ^ (~h[4] & h[6])) + round_k[i] + w[i];
      t2 = (ror32(h[0], 2) ^ ror32(h[0], 13) ^ ror32(h[0], 22)) +
           ((h[0] & h[1]) ^ (h[0] & h[2]) ^ (h[1] & h[2]));
      h[7] = h[6]; h[6] = h[5]; h[5] = h[4]; h[4] = h[3] + t1;
      h[3] = h[2]; h[2] = h[1]; h[1] = h[0]; h[0] = t1 + t2;
    end
    return {swap_bytes(h[1] + 32'hbb67ae85), swap_bytes(h[0] + 32'h6a09e667)};
  endfunction

  function automatic word_t mul_mod(word_t x, word_t y, word_t m);
    dword_t prod;
    prod = dword_t'(x) * dword_t'(y);
    return word_t'(prod % dword_t'(m));
  endfunction

  function automatic word_t pow_mod(word_t b, word_t e, word_t m);
    word_t r;
    r = word_t'(64'd1 % m);
    b = b % m;
    for (int i = 0; i < 64; i++) begin
      if (e[i]) r = mul_mod(r, b, m);
      b = mul_mod(b, b, m);
    end
    return r;
  endfunction

  // verdict of one proof under the current register values
  function automatic verdict_t judge_proof(proof_t pr);
    verdict_t v;
    logic [2:0] why;
    word_t lhs, rhs;
    if (pr.a == '0 || pr.a >= mod_q) begin
      why = spv_pkg::ReasonARange;
    end else if (pr.z >= mod_q - 64'd1) begin
      why = spv_pkg::ReasonZRange;
    end else if (challenge_hash(gen_q, key_q, pr.a, mod_q) % (mod_q - 64'd1) != pr.c) begin
      why = spv_pkg::ReasonMismatch;
    end else begin
      lhs = pow_mod(gen_q, pr.z, mod_q);
      rhs = mul_mod(pr.a, pow_mod(key_q, pr.c, mod_q), mod_q);
      why = (lhs == rhs) ? spv_pkg::ReasonOk : spv_pkg::ReasonEquation;
    end
    v.accepted = (why == spv_pkg::ReasonOk);
    v.reason   = why;
    return v;
  endfunction

  // valid proof for nonce k and secret s under p and g
  function automatic proof_t make_proof(word_t p, word_t g, word_t s, word_t k);
    proof_t pr;
    word_t  x, q;
    q    = p - 64'd1;
    x    = pow_mod(g, s, p);
    pr.a = pow_mod(g, k, p);
    pr.c = challenge_hash(g, x, pr.a, p) % q;
    pr.z = word_t'((dword_t'(k % q) + dword_t'(mul_mod(pr.c, s, q))) % dword_t'(q));
    return pr;
  endfunction

  // ----------------------------------------------------------- stimulus

  // drop the input offer, then wait for every verdict
  task automatic wait_drained();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(word_t idx, word_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      spv_pkg::RegModulus:   mod_q = val;
      spv_pkg::RegGenerator: gen_q = val;
      default:               key_q = val;
    endcase
  endtask

  // new group setting, only once every verdict is back
  task automatic set_group(word_t p, word_t g, word_t x);
    wait_drained();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    write_reg(spv_pkg::RegModulus, p);
    write_reg(spv_pkg::RegGenerator, g);
    write_reg(spv_pkg::RegPublicKey, x);
    cfg_valid_i <= 1'b0;
  endtask

  // one input beat; gap of zero keeps tvalid high into the next item
  task automatic send_proof(proof_t pr, int gap, bit typed, logic [2:0] why);
    verdict_t v;
    if (gap > 0) begin
      if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pr.z, pr.c, pr.a};
    do @(posedge clk_i); while (!s_axis_tready);
    v = judge_proof(pr);
    if (typed) begin
      v.reason   = why;
      v.accepted = (why == spv_pkg::ReasonOk);
    end
    verdict_q.push_back(v);
    proofs_sent++;
  endtask

  function automatic int draw_gap(bit burst);
    return burst ? 0 : int'($urandom_range(0, 19));
  endfunction

  row_t rows[$];

  initial begin
    proof_t pr;
    row_t   r;
    word_t  p, g, s, k;
    int     pick;
    bit     burst;

    mod_q = spv_pkg::ModulusReset;
    gen_q = spv_pkg::GeneratorReset;
    key_q = spv_pkg::PublicKeyReset;
    mismatches = 0;
    proofs_sent = 0;
    hold_rx = 1'b0;

    // directed rows: reset setting first
    rows.push_back('{RowRaw, spv_pkg::ModulusReset, spv_pkg::GeneratorReset,
                     spv_pkg::PublicKeyReset, 64'd0, 64'd0, 64'd0, 1,
                     spv_pkg::ReasonARange});
    rows.push_back('{RowRaw, spv_pkg::ModulusReset, spv_pkg::GeneratorReset,
                     spv_pkg::PublicKeyReset, 64'd5, 64'd0, 64'd0, 1,
                     spv_pkg::ReasonARange});
    rows.push_back('{RowRaw, spv_pkg::ModulusReset, spv_pkg::GeneratorReset,
                     spv_pkg::PublicKeyReset, 64'd1, 64'd0, 64'd4, 1,
                     spv_pkg::ReasonZRange});
    rows.push_back('{RowRaw, spv_pkg::ModulusReset, spv_pkg::GeneratorReset,
                     spv_pkg::PublicKeyReset, 64'd4, 64'd0, 64'd0, 0,
                     spv_pkg::ReasonOk});
    rows.push_back('{RowHonest, 64'd5, 64'd2, 64'd3, 64'd1, 0, 0, 0, spv_pkg::ReasonOk});
    rows.push_back('{RowHonest, 64'd3, 64'd2, 64'd1, 64'd0, 0, 0, 0, spv_pkg::ReasonOk});
    // generators above the modulus, and a raw key above it too
    rows.push_back('{RowHonest, 64'd11, 64'd24, 64'd7, 64'd4, 0, 0, 0, spv_pkg::ReasonOk});
    rows.push_back('{RowRaw, 64'd11, 64'd35, 64'd100, 64'd3, 64'd9, 64'd0, 0,
                     spv_pkg::ReasonOk});
    // widest group
    rows.push_back('{RowRaw, BigPrime, MaxWord, MaxWord, MaxWord, MaxWord, 64'd1,
                     1, spv_pkg::ReasonARange});
    rows.push_back('{RowRaw, BigPrime, MaxWord, MaxWord, 64'd1, 64'd0, MaxWord,
                     1, spv_pkg::ReasonZRange});
    rows.push_back('{RowRaw, BigPrime, MaxWord, MaxWord, BigPrime - 64'd1, MaxWord,
                     BigPrime - 64'd2, 0, spv_pkg::ReasonOk});
    rows.push_back('{RowHonest, BigPrime, 64'h8000_0000_0000_0003,
                     64'h7fff_1234_5678_9abc, 64'hfedc_ba98_7654_3210, 0, 0, 0,
                     spv_pkg::ReasonOk});
    rows.push_back('{RowForged, BigPrime, 64'd3, 64'h0123_4567_89ab_cdef,
                     64'd77, 0, 0, 0, spv_pkg::ReasonOk});
    rows.push_back('{RowHonest, 64'h1fff_ffff_ffff_ffff, 64'd7, 64'd0, 64'd0,
                     0, 0, 0, spv_pkg::ReasonOk});
    // zero generator and zero key
    rows.push_back('{RowRaw, 64'd13, 64'd0, 64'd0, 64'd1, 64'd0, 64'd0, 0,
                     spv_pkg::ReasonOk});

    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    foreach (rows[i]) begin
      r = rows[i];
      if (r.kind == RowRaw) begin
        if (r.p != mod_q || r.g != gen_q || r.key != key_q) set_group(r.p, r.g, r.key);
        pr = '{r.a, r.c, r.z};
      end else begin
        s = pow_mod(r.g, r.key, r.p);
        if (r.p != mod_q || r.g != gen_q || s != key_q) set_group(r.p, r.g, s);
        pr = make_proof(r.p, r.g, r.key, r.a);
        if (r.kind == RowForged) pr.z = (pr.z == '0) ? 64'd1 : pr.z - 64'd1;
      end
      send_proof(pr, draw_gap(i % 4 == 0), r.typed, r.reason);
    end

    // back-pressure: receiver held while range rejects pile up
    wait_drained();
    hold_rx = 1'b1;
    for (int i = 0; i < 6; i++)
      send_proof('{64'd0, 64'd0, 64'd0}, 0, 1, spv_pkg::ReasonARange);
    hold_rx = 1'b0;

    // random phases of about twenty proofs each
    for (int n = 0; n < RandomItems; ) begin
      if ($urandom_range(0, 4) == 0) p = {$urandom, $urandom} | 64'd3;
      else p = prime_list[$urandom_range(0, 9)];
      g = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) g = g % p;
      if (g % p == '0) g = 64'd2;
      s = {$urandom, $urandom};
      set_group(p, g, pow_mod(g, s, p));
      burst = ($urandom_range(0, 2) == 0);
      for (int j = 0; j < 20 && n < RandomItems; j++, n++) begin
        k = {$urandom, $urandom};
        pr = make_proof(p, g, s, k);
        pick = $urandom_range(0, 9);
        case (pick)
          7: pr.z = pr.z ^ (64'd1 << $urandom_range(0, 63));
          8: pr.c = pr.c + 64'd1;
          9: pr = '{{$urandom, $urandom} >> $urandom_range(0, 63),
                    {$urandom, $urandom}, {$urandom, $urandom} >> $urandom_range(0, 63)};
          default: ;
        endcase
        send_proof(pr, draw_gap(burst), 0, spv_pkg::ReasonOk);
      end
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("covered %0d proofs (%0d verdicts, %0d accepted) across directed and random groups",
             proofs_sent, verdicts_seen, accepted_seen);
    $display("range, challenge and equation rejects with random stalls and a held receiver");
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // ------------------------------------------------------------ receiver

  initial begin
    verdict_t got, want;
    int stall;
    verdicts_seen = 0;
    accepted_seen = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
      if (hold_rx) stall = 3000;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      // accepted in bit 0, reason above it
      got.accepted = m_axis_tdata[0];
      got.reason   = m_axis_tdata[3:1];
      verdicts_seen++;
      if (got.accepted) accepted_seen++;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected verdict beat: %b/%0d", got.accepted, got.reason);
      end else begin
        want = verdict_q.pop_front();
        if (got.accepted !== want.accepted || got.reason !== want.reason) begin
          mismatches++;
          if (mismatches <= 10)
            $display("verdict %0d: expected accepted=%b reason=%0d, got accepted=%b reason=%0d",
                     verdicts_seen, want.accepted, want.reason, got.accepted, got.reason);
        end
      end
    end
  end

  // watchdog
  initial begin
    #100ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[schnorr_proof_verify.f]
+incdir+hw/rtl
hw/rtl/spv_pkg.sv
hw/rtl/spv_datapath.sv
hw/rtl/spv_ctrl.sv
hw/rtl/schnorr_proof_verify.sv
tb/tb.sv
